// ===== rtl/vpd_pkg.sv =====
// shared types and codes for the varint packet deframer
// no dependencies; imported by every module of the block except vpd_queue
package vpd_pkg;

  localparam int VarintCountWidth = 3;
  localparam int WordWidth        = 32;

  typedef enum logic [1:0] {
    PH_LENGTH = 2'd0,
    PH_XLEN   = 2'd1,
    PH_ID     = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER     = 2'd0,
    KIND_PAYLOAD    = 2'd1,
    KIND_COMPRESSED = 2'd2,
    KIND_ERROR      = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERLONG = 2'd1,
    ERR_SHORT    = 2'd2
  } err_t;

  // classified byte from the front end
  typedef struct packed {
    logic       more;   // varint continuation flag
    logic [6:0] bits;
  } byte_item_t;

  typedef struct packed {
    kind_t                  kind;
    logic [7:0]             payload_byte;
    logic [WordWidth-1:0]   packet_id;
    logic [WordWidth-1:0]   expanded_length;
    logic                   packet_end;
    err_t                   error_code;
  } result_t;

endpackage

// ===== rtl/varint_packet_deframer.sv =====
// top level of the varint length-prefixed packet deframer
// depends on vpd_pkg, vpd_front, vpd_core and vpd_queue
//
// Accepts one link byte per cycle and returns exactly one result per byte, in
// order, with a sustained rate of one byte per clock when the result side pops
// every cycle. A byte is first registered in the input queue; the combinational
// varint and length update of the framing core then writes its result into the
// result queue, from which it is popped. Each queue holds QUEUE_DEPTH entries,
// so either side may stall without stopping the other until that queue fills.
// compression_on is sampled when a packet length completes and should only be
// written while no bytes are in flight; cfg_ready is always high.
module varint_packet_deframer #(
  parameter int MAX_VARINT_BYTES = 5,
  parameter int QUEUE_DEPTH      = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  // byte input
  input  logic               in_push,
  input  logic [7:0]         in_data_byte,
  output logic               in_full,
  // results
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_kind,
  output logic [7:0]         out_payload_byte,
  output logic signed [31:0] out_packet_id,
  output logic signed [31:0] out_expanded_length,
  output logic               out_packet_end,
  output logic [1:0]         out_error_code,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_compression_on
);
  import vpd_pkg::*;

  logic                       compression_on_r;
  byte_item_t                 item;
  logic                       item_valid;
  logic                       item_take;
  result_t                    res;
  logic                       res_valid;
  logic                       outq_full;
  logic [$bits(result_t)-1:0] outq_rdata;
  result_t                    head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compression_on_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      compression_on_r <= cfg_compression_on;
    end
  end

  vpd_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_full      (in_full),
    .item         (item),
    .item_valid   (item_valid),
    .item_take    (item_take)
  );

  vpd_core #(
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .compression_on (compression_on_r),
    .item           (item),
    .item_valid     (item_valid),
    .item_take      (item_take),
    .res            (res),
    .res_valid      (res_valid),
    .res_ready      (~outq_full)
  );

  vpd_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata (res),
    .full  (outq_full),
    .pop   (out_pop),
    .rdata (outq_rdata),
    .empty (out_empty)
  );

  assign head                = result_t'(outq_rdata);
  assign out_kind            = head.kind;
  assign out_payload_byte    = head.payload_byte;
  assign out_packet_id       = $signed(head.packet_id);
  assign out_expanded_length = $signed(head.expanded_length);
  assign out_packet_end      = head.packet_end;
  assign out_error_code      = head.error_code;

endmodule

// ===== rtl/vpd_queue.sv =====
// small synchronous fifo built from registers, used on both sides of the core
// no package dependencies
module vpd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/vpd_front.sv =====
// front end: takes link bytes, splits off the continuation flag, queues them
// depends on vpd_pkg and vpd_queue
module vpd_front #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic [7:0]          in_data_byte,
  output logic                in_full,
  output vpd_pkg::byte_item_t item,
  output logic                item_valid,
  input  logic                item_take
);
  import vpd_pkg::*;

  byte_item_t                  cls;
  logic [$bits(byte_item_t)-1:0] q_rdata;
  logic                        q_empty;

  assign cls.more = in_data_byte[7];
  assign cls.bits = in_data_byte[6:0];

  vpd_queue #(
    .WIDTH ($bits(byte_item_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (cls),
    .full  (in_full),
    .pop   (item_take),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign item       = byte_item_t'(q_rdata);
  assign item_valid = ~q_empty;

endmodule

// ===== rtl/vpd_core.sv =====
// back end: varint decoding and packet framing state machine, one byte a cycle while the result queue has room
// depends on vpd_pkg
module vpd_core #(
  parameter int MAX_VARINT_BYTES = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                compression_on,
  input  vpd_pkg::byte_item_t item,
  input  logic                item_valid,
  output logic                item_take,
  output vpd_pkg::result_t    res,
  output logic                res_valid,
  input  logic                res_ready
);
  import vpd_pkg::*;

  phase_t                      phase_r, phase_nxt;
  logic [WordWidth-1:0]        acc_r, acc_nxt;
  logic [VarintCountWidth-1:0] cnt_r, cnt_nxt;
  logic [WordWidth-1:0]        rem_r, rem_nxt;
  logic [WordWidth-1:0]        id_r, id_nxt;
  logic [WordWidth-1:0]        xlen_r, xlen_nxt;

  logic [WordWidth-1:0]        rem_dec;
  logic [WordWidth-1:0]        shifted;
  logic [WordWidth-1:0]        acc_sum;
  logic [VarintCountWidth-1:0] cnt_inc;
  logic                        take;
  kind_t                       kind;
  logic [7:0]                  pay;
  logic                        pend;
  err_t                        err;

  assign take      = item_valid & res_ready;
  assign item_take = take;
  assign res_valid = item_valid;

  // place the payload bits at their group position, only the low four in the fifth group
  always_comb begin
    case (cnt_r)
      3'd0:    shifted = {25'd0, item.bits};
      3'd1:    shifted = {18'd0, item.bits, 7'd0};
      3'd2:    shifted = {11'd0, item.bits, 14'd0};
      3'd3:    shifted = {4'd0, item.bits, 21'd0};
      3'd4:    shifted = {item.bits[3:0], 28'd0};
      default: shifted = '0;
    endcase
  end

  assign acc_sum = acc_r | shifted;
  assign cnt_inc = cnt_r + 1'b1;
  assign rem_dec = (phase_r != PH_LENGTH && rem_r != '0) ? rem_r - 1'b1 : rem_r;

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    id_nxt    = id_r;
    xlen_nxt  = xlen_r;
    kind      = KIND_HEADER;
    pay       = '0;
    pend      = 1'b0;
    err       = ERR_NONE;

    if (take) begin
      rem_nxt = rem_dec;
      if (phase_r == PH_BODY) begin
        pay  = {item.more, item.bits};
        kind = (xlen_r != '0) ? KIND_COMPRESSED : KIND_PAYLOAD;
        if (rem_dec == '0) begin
          pend      = 1'b1;
          phase_nxt = PH_LENGTH;
        end
      end else if (!item.more) begin
        acc_nxt = '0;
        cnt_nxt = '0;
        case (phase_r)
          PH_LENGTH: begin
            if (acc_sum == '0 || acc_sum[WordWidth-1]) begin
              err = ERR_SHORT;
            end else begin
              rem_nxt   = acc_sum;
              id_nxt    = '0;
              xlen_nxt  = '0;
              phase_nxt = compression_on ? PH_XLEN : PH_ID;
            end
          end
          PH_XLEN: begin
            if (acc_sum != '0) begin
              xlen_nxt = acc_sum;
              if (rem_dec == '0) begin
                pend      = 1'b1;
                phase_nxt = PH_LENGTH;
              end else begin
                phase_nxt = PH_BODY;
              end
            end else if (rem_dec == '0) begin
              err = ERR_SHORT;
            end else begin
              phase_nxt = PH_ID;
            end
          end
          default: begin
            id_nxt = acc_sum;
            if (rem_dec == '0) begin
              pend      = 1'b1;
              phase_nxt = PH_LENGTH;
            end else begin
              phase_nxt = PH_BODY;
            end
          end
        endcase
      end else if (cnt_inc >= VarintCountWidth'(MAX_VARINT_BYTES)) begin
        err = ERR_OVERLONG;
      end else if (phase_r != PH_LENGTH && rem_dec == '0) begin
        err = ERR_SHORT;
      end else begin
        acc_nxt = acc_sum;
        cnt_nxt = cnt_inc;
      end

      // resynchronise on the next length
      if (err != ERR_NONE) begin
        phase_nxt = PH_LENGTH;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        rem_nxt   = '0;
        id_nxt    = '0;
        xlen_nxt  = '0;
        kind      = KIND_ERROR;
        pay       = '0;
        pend      = 1'b0;
      end
    end

    res.kind            = kind;
    res.payload_byte    = pay;
    res.packet_id       = id_nxt;
    res.expanded_length = xlen_nxt;
    res.packet_end      = pend;
    res.error_code      = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LENGTH;
      acc_r   <= '0;
      cnt_r   <= '0;
      rem_r   <= '0;
      id_r    <= '0;
      xlen_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      id_r    <= id_nxt;
      xlen_r  <= xlen_nxt;
    end
  end

`ifndef SYNTH
  a_err_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    take && res.error_code != ERR_NONE |->
      res.kind == KIND_ERROR && res.packet_id == '0 && res.expanded_length == '0
      && !res.packet_end)
    else $error("error result carries stale fields");

  a_err_resyncs: assert property (@(posedge clk) disable iff (!rst_n)
    take && res.error_code != ERR_NONE |=>
      phase_r == PH_LENGTH && rem_r == '0 && cnt_r == '0 && acc_r == '0)
    else $error("state not cleared after error");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < VarintCountWidth'(MAX_VARINT_BYTES))
    else $error("varint byte count past limit");

  a_body_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> rem_r != '0)
    else $error("body phase with nothing left in packet");
`endif

endmodule
